// File: rtl/core/srb_pkg.sv
`default_nettype none

package srb_pkg;

    // field widths of the stream items
    localparam int OP_W   = 2;
    localparam int POS_W  = 32;
    localparam int BYTE_W = 8;

    // input tdata: stream_index, byte_value, segment_length
    localparam int IN_TDATA_W = 72;

    localparam logic [POS_W-1:0] POS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLOSE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_WMARK  = 6'b001000,
        ST_PROMO  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  idx;
        logic [BYTE_W-1:0] byte_val;
        logic [POS_W-1:0]  seg_len;
        logic              eos;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/core/srb_ram.sv
`default_nettype none

module srb_ram
    import srb_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read; hold the last read word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/stream_byte_reassembler_core.sv
// Channel   Dir  tdata (low bit up)                                  tuser         tlast
// s_axis    in   stream_index[31:0] byte_value[39:32]                operation[1:0] end_of_stream
//                segment_length[71:40]
// m_axis    out  read_byte[7:0] assembled_total[39:8]                read_valid    stream_ended
//                unassembled_count[40+CNT_W-1:40], zero padded
//
// One transfer in gives exactly one transfer out.
// A read goes from idle to the result state; a close or unknown op passes the execute
// state first; a write passes execute, the mark state when inside the window, then the
// promotion walk over the present-mark memory, stopping at a missing mark or the window limit.
// After rst_n rises, a clearing pass wipes the present marks;
// s_axis_tready stays low until it completes.
// A stalled m_axis holds its result; the next item is still taken and waits in
// the result state until the output register frees.
`default_nettype none

module stream_byte_reassembler_core
    import srb_pkg::*;
#(
    parameter int CAPACITY     = 4096,
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int OUT_TDATA_W = ((BYTE_W + POS_W + CNT_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // stream_index, byte_value, segment_length
    input  logic [OP_W-1:0]        s_axis_tuser,   // operation
    input  logic                   s_axis_tlast,   // end_of_stream

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_byte, assembled_total, unassembled_count
    output logic                   m_axis_tuser,   // read_valid
    output logic                   m_axis_tlast    // stream_ended
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW:0]   CAP_X     = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] SLOT_LAST = AW'(CAPACITY - 1);

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [POS_W-1:0]  lim_reg, lim_next;
    logic [POS_W-1:0]  ne_reg, ne_next;
    logic [AW-1:0]     ne_slot_reg, ne_slot_next;
    logic [POS_W-1:0]  rp_reg, rp_next;
    logic [AW-1:0]     rp_slot_reg, rp_slot_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic              end_known_reg, end_known_next;
    logic [POS_W-1:0]  end_pos_reg, end_pos_next;
    logic              ended_reg, ended_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     wslot_reg, wslot_next;
    logic              fwd_reg, fwd_next;
    logic              rvalid_reg, rvalid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;
    logic                   out_last_reg, out_last_next;

    // memory ports
    logic              data_we, data_re;
    logic [AW-1:0]     data_waddr, data_raddr;
    logic [BYTE_W-1:0] data_rdata;
    logic              mark_we, mark_wdata, mark_re;
    logic [AW-1:0]     mark_waddr, mark_raddr;
    logic              mark_rdata;

    // helpers
    item_t             in_item;
    logic              accept;
    logic [POS_W:0]    lim_sum;
    logic [POS_W-1:0]  lim_base, lim_now;
    logic [POS_W-1:0]  off;
    logic [AW:0]       slot_sum;
    logic [AW-1:0]     wslot;
    logic              in_win;
    logic [POS_W:0]    end_sum;
    logic [POS_W-1:0]  end_val;
    logic [POS_W-1:0]  ne_inc;
    logic [AW-1:0]     ne_slot_inc, rp_slot_inc;
    logic              mark_bit;
    logic              ended_now;
    logic [BYTE_W-1:0] rbyte;

    srb_ram #(.DEPTH(CAPACITY), .WIDTH(BYTE_W)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (item_reg.byte_val),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    srb_ram #(.DEPTH(CAPACITY), .WIDTH(1)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign in_item.op       = op_t'(s_axis_tuser);
    assign in_item.idx      = s_axis_tdata[31:0];
    assign in_item.byte_val = s_axis_tdata[39:32];
    assign in_item.seg_len  = s_axis_tdata[71:40];
    assign in_item.eos      = s_axis_tlast;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // window limit: read position plus capacity, saturated, clipped at known end
    assign lim_sum  = {1'b0, rp_reg} + (POS_W + 1)'(CAPACITY);
    assign lim_base = lim_sum[POS_W] ? POS_MAX : lim_sum[POS_W-1:0];
    assign lim_now  = (end_known_reg && (end_pos_reg < lim_base)) ? end_pos_reg : lim_base;

    // slot of an in-window index, taken relative to the read slot
    assign off      = item_reg.idx - rp_reg;
    assign slot_sum = {1'b0, rp_slot_reg} + {1'b0, off[AW-1:0]};
    assign wslot    = (slot_sum >= CAP_X) ? AW'(slot_sum - CAP_X) : slot_sum[AW-1:0];
    assign in_win   = (item_reg.idx >= ne_reg) && (item_reg.idx < lim_reg);

    assign end_sum = {1'b0, item_reg.idx} + {1'b0, item_reg.seg_len};
    assign end_val = end_sum[POS_W] ? POS_MAX : end_sum[POS_W-1:0];

    assign ne_inc      = ne_reg + 1'b1;
    assign ne_slot_inc = (ne_slot_reg == SLOT_LAST) ? '0 : ne_slot_reg + 1'b1;
    assign rp_slot_inc = (rp_slot_reg == SLOT_LAST) ? '0 : rp_slot_reg + 1'b1;

    // mark just set by the write stage is not yet visible on the first walk read
    assign mark_bit  = fwd_reg | mark_rdata;
    assign ended_now = ended_reg | (end_known_reg && (ne_reg == end_pos_reg));
    assign rbyte     = rvalid_reg ? data_rdata : '0;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        lim_next       = lim_reg;
        ne_next        = ne_reg;
        ne_slot_next   = ne_slot_reg;
        rp_next        = rp_reg;
        rp_slot_next   = rp_slot_reg;
        pend_next      = pend_reg;
        end_known_next = end_known_reg;
        end_pos_next   = end_pos_reg;
        ended_next     = ended_reg;
        clr_next       = clr_reg;
        wslot_next     = wslot_reg;
        fwd_next       = fwd_reg;
        rvalid_next    = rvalid_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;

        data_we    = 1'b0;
        data_waddr = wslot;
        data_re    = 1'b0;
        data_raddr = rp_slot_reg;
        mark_we    = 1'b0;
        mark_waddr = ne_slot_reg;
        mark_wdata = 1'b0;
        mark_re    = 1'b0;
        mark_raddr = ne_slot_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // wipe one present mark per cycle
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next   = in_item;
                    lim_next    = lim_now;
                    rvalid_next = 1'b0;
                    if (in_item.op == OP_READ)
                    begin
                        if (rp_reg < ne_reg)
                        begin
                            data_re      = 1'b1;
                            rvalid_next  = 1'b1;
                            rp_next      = rp_reg + 1'b1;
                            rp_slot_next = rp_slot_inc;
                        end
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                case (item_reg.op)
                    OP_WRITE:
                    begin
                        fwd_next = 1'b0;
                        if (in_win)
                        begin
                            // store the byte, fetch its present mark
                            data_we    = 1'b1;
                            mark_re    = 1'b1;
                            mark_raddr = wslot;
                            wslot_next = wslot;
                            state_next = ST_WMARK;
                        end
                        else if (ne_reg < lim_reg)
                        begin
                            mark_re    = 1'b1;
                            state_next = ST_PROMO;
                        end
                        else
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    OP_CLOSE:
                    begin
                        if (item_reg.eos && (item_reg.idx < lim_reg))
                        begin
                            end_known_next = 1'b1;
                            end_pos_next   = end_val;
                        end
                        state_next = ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_WMARK:
            begin
                // set the mark; count only a byte that was not there yet
                mark_we    = 1'b1;
                mark_waddr = wslot_reg;
                mark_wdata = 1'b1;
                if (!mark_rdata)
                begin
                    pend_next = pend_reg + 1'b1;
                end
                if (ne_reg < lim_reg)
                begin
                    mark_re    = 1'b1;
                    fwd_next   = (wslot_reg == ne_slot_reg);
                    state_next = ST_PROMO;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_PROMO:
            begin
                fwd_next = 1'b0;
                if (mark_bit)
                begin
                    // promote one byte, look ahead at the next slot
                    mark_we      = 1'b1;
                    mark_waddr   = ne_slot_reg;
                    mark_wdata   = 1'b0;
                    ne_next      = ne_inc;
                    ne_slot_next = ne_slot_inc;
                    if (pend_reg != '0)
                    begin
                        pend_next = pend_reg - 1'b1;
                    end
                    if (ne_inc < lim_reg)
                    begin
                        mark_re    = 1'b1;
                        mark_raddr = ne_slot_inc;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                ended_next = ended_now;
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({pend_reg, ne_reg, rbyte});
                    out_user_next  = rvalid_reg;
                    out_last_next  = ended_now;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ne_reg        <= '0;
            ne_slot_reg   <= '0;
            rp_reg        <= '0;
            rp_slot_reg   <= '0;
            pend_reg      <= '0;
            end_known_reg <= 1'b0;
            end_pos_reg   <= '0;
            ended_reg     <= 1'b0;
            clr_reg       <= '0;
            fwd_reg       <= 1'b0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            ne_slot_reg   <= ne_slot_next;
            rp_reg        <= rp_next;
            rp_slot_reg   <= rp_slot_next;
            pend_reg      <= pend_next;
            end_known_reg <= end_known_next;
            end_pos_reg   <= end_pos_next;
            ended_reg     <= ended_next;
            clr_reg       <= clr_next;
            fwd_reg       <= fwd_next;
            rvalid_reg    <= rvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        lim_reg      <= lim_next;
        wslot_reg    <= wslot_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/srb_checker.sv
`default_nettype none

module srb_checker
    import srb_pkg::*;
#(
    parameter int CAPACITY     = 4096,
    localparam int CNT_W       = $clog2(CAPACITY + 1),
    localparam int OUT_TDATA_W = ((BYTE_W + POS_W + CNT_W + 7) / 8) * 8
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser,
    input logic                   m_axis_tlast
);

    localparam int TOT_LO = BYTE_W;
    localparam int CNT_LO = BYTE_W + POS_W;

    logic             xfer;
    logic             seen_end_reg;
    logic [POS_W-1:0] last_total_reg;

    assign xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_end_reg   <= 1'b0;
            last_total_reg <= '0;
        end
        else if (xfer)
        begin
            seen_end_reg   <= seen_end_reg | m_axis_tlast;
            last_total_reg <= m_axis_tdata[TOT_LO +: POS_W];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_end_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && seen_end_reg |-> m_axis_tlast)
        else $error("stream end flag dropped");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[TOT_LO +: POS_W] >= last_total_reg)
        else $error("assembled total went backward");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[BYTE_W-1:0] == '0)
        else $error("byte reported without a read hit");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[CNT_LO +: CNT_W]) <= 32'(CAPACITY))
        else $error("unassembled count above capacity");

endmodule

bind stream_byte_reassembler_core srb_checker #(.CAPACITY(CAPACITY)) u_srb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import srb_pkg::*;

    localparam int CAP          = 4096;
    localparam int CNT_W        = $clog2(CAP + 1);
    localparam int OUT_W        = ((BYTE_W + POS_W + CNT_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 930;
    localparam int STALL_LIMIT  = 60000;

    typedef struct packed {
        logic [BYTE_W-1:0] rbyte;
        logic              rvalid;
        logic [POS_W-1:0]  total;
        logic [CNT_W-1:0]  held;
        logic              ended;
    } reasm_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // mirror of the reassembly state
    bit [BYTE_W-1:0]       mirror_bytes [CAP];
    bit                    mirror_held  [CAP];
    logic [POS_W-1:0]      next_pos  = '0;
    logic [POS_W-1:0]      read_pos  = '0;
    logic [CNT_W-1:0]      held_count = '0;
    logic                  end_seen  = 1'b0;
    logic [POS_W-1:0]      end_pos   = '0;
    logic                  ended     = 1'b0;

    reasm_status_t         status_due [$];
    reasm_status_t         want;

    int unsigned           burst_left = 0;
    int unsigned           rx_mode    = 0;
    int unsigned           rx_left    = 0;
    int unsigned           rx_tick    = 0;
    int unsigned           quiet_cycles = 0;
    int unsigned           errors     = 0;
    int unsigned           items_sent = 0;
    int unsigned           results_checked = 0;
    int unsigned           bytes_read = 0;
    int unsigned           noise_sent = 0;

    stream_byte_reassembler_core #(
        .CAPACITY (CAP)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic int unsigned slot_of_pos(logic [POS_W-1:0] p);
        return p % CAP;
    endfunction

    // Upper bound (exclusive) of accepted positions: read position plus
    // capacity, saturated, then clipped at the known end.
    function automatic logic [POS_W-1:0] window_end();
        logic [POS_W:0] lim;
        lim = {1'b0, read_pos} + (POS_W+1)'(CAP);
        if (lim > {1'b0, POS_MAX})
            lim = {1'b0, POS_MAX};
        if (end_seen && {1'b0, end_pos} < lim)
            lim = {1'b0, end_pos};
        return lim[POS_W-1:0];
    endfunction

    // Advance the mirror by one accepted item and return the status it reports.
    task automatic reassemble(input item_t it, output reasm_status_t st);
        logic [POS_W-1:0] lim;
        logic [POS_W:0]   stop;
        int unsigned      s;
        st = '0;
        case (it.op)
            OP_WRITE:
            begin
                lim = window_end();
                if (it.idx >= next_pos && it.idx < lim)
                begin
                    s = slot_of_pos(it.idx);
                    mirror_bytes[s] = it.byte_val;
                    if (!mirror_held[s])
                    begin
                        mirror_held[s] = 1'b1;
                        held_count++;
                    end
                end
                // promote whatever became contiguous, even after a dropped byte
                while (next_pos < lim && mirror_held[slot_of_pos(next_pos)])
                begin
                    mirror_held[slot_of_pos(next_pos)] = 1'b0;
                    next_pos++;
                    if (held_count != 0)
                        held_count--;
                end
            end
            OP_CLOSE:
            begin
                if (it.eos && it.idx < window_end())
                begin
                    stop = {1'b0, it.idx} + {1'b0, it.seg_len};
                    if (stop > {1'b0, POS_MAX})
                        stop = {1'b0, POS_MAX};
                    end_seen = 1'b1;
                    end_pos  = stop[POS_W-1:0];
                end
            end
            OP_READ:
            begin
                if (read_pos < next_pos)
                begin
                    st.rbyte  = mirror_bytes[slot_of_pos(read_pos)];
                    st.rvalid = 1'b1;
                    read_pos++;
                end
            end
            default:
            begin
            end
        endcase
        if ((it.op == OP_WRITE || it.op == OP_CLOSE) && end_seen && next_pos == end_pos)
            ended = 1'b1;
        st.total = next_pos;
        st.held  = held_count;
        st.ended = ended;
    endtask

    // Offer one item; the sender runs in bursts with random gaps between them.
    task automatic send_item(input op_t op, input logic [POS_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic [POS_W-1:0] len,
                             input logic eos);
        item_t         it;
        reasm_status_t st;
        int unsigned   gap;
        it = '{op, idx, val, len, eos};
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, val, idx};
        s_axis_tuser  <= op;
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        reassemble(it, st);
        status_due.push_back(st);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic void check_field(string name, logic [POS_W-1:0] exp_val,
                                        logic [POS_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            errors++;
        end
    endfunction

    // Compare every result transfer with the oldest status still due.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid && m_axis_tready)
        begin
            if (status_due.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                errors++;
            end
            else
            begin
                want = status_due.pop_front();
                check_field("read_byte", want.rbyte, m_axis_tdata[7:0]);
                check_field("read_valid", want.rvalid, m_axis_tuser);
                check_field("assembled_total", want.total, m_axis_tdata[39:8]);
                check_field("unassembled_count", want.held, m_axis_tdata[40+CNT_W-1:40]);
                check_field("stream_ended", want.ended, m_axis_tlast);
                results_checked++;
                if (want.rvalid)
                    bytes_read++;
            end
        end
    end

    // Receiver: switch between always ready, light, periodic and heavy stalls.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) >= 4);
            2:       m_axis_tready <= ((rx_tick % 4) != 0);
            default: m_axis_tready <= ($urandom_range(0, 9) >= 8);
        endcase
    end

    // Watchdog: the clearing pass and a full-window promotion are the longest
    // stretches without a transfer, both far below the limit.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, status_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_empty_and_unknown();
        send_item(OP_READ, '0, '0, '0, 1'b0);
        send_item(OP_NONE, POS_MAX, 8'hFF, POS_MAX, 1'b1);
    endtask

    task automatic test_in_order();
        send_item(OP_WRITE, 32'd0, 8'h00, '0, 1'b0);
        send_item(OP_WRITE, 32'd1, 8'hFF, '0, 1'b0);
        send_item(OP_READ, '0, '0, '0, 1'b0);
        send_item(OP_READ, '0, '0, '0, 1'b0);
    endtask

    task automatic test_out_of_order();
        logic [POS_W-1:0] base;
        base = next_pos;
        send_item(OP_WRITE, base + 2, 8'hA5, '0, 1'b0);
        send_item(OP_WRITE, base + 1, 8'h5A, '0, 1'b0);
        // duplicate: overwrite, do not count again
        send_item(OP_WRITE, base + 2, 8'h3C, '0, 1'b0);
        // stale byte below the expected position
        send_item(OP_WRITE, base - 1, 8'h11, '0, 1'b0);
        // first position past the window, then the last one inside it
        send_item(OP_WRITE, read_pos + CAP, 8'h22, '0, 1'b0);
        send_item(OP_WRITE, read_pos + CAP - 1, 8'h44, '0, 1'b0);
        send_item(OP_WRITE, POS_MAX, 8'h81, '0, 1'b0);
        // fill the gap: three bytes promote at once
        send_item(OP_WRITE, base, 8'h7E, '0, 1'b0);
        repeat (3) send_item(OP_READ, '0, '0, '0, 1'b0);
    endtask

    task automatic test_segment_close();
        logic [POS_W-1:0] base;
        base = next_pos;
        send_item(OP_CLOSE, base, '0, POS_MAX, 1'b0);
        send_item(OP_CLOSE, 32'h8000_0000, '0, '0, 1'b1);
        send_item(OP_CLOSE, base, '0, 32'd2, 1'b1);
        // window now clipped at the recorded end
        send_item(OP_WRITE, base + 2, 8'h99, '0, 1'b0);
        send_item(OP_WRITE, base, 8'h12, '0, 1'b0);
        send_item(OP_WRITE, base + 1, 8'h34, '0, 1'b0);
        // a later close moves the end out, saturated at the top position
        send_item(OP_CLOSE, base + 1, '0, POS_MAX, 1'b1);
    endtask

    // Mostly well-formed segments written in some order and sometimes closed, with
    // reads to drain; the rest is stale, out-of-window and unknown traffic.
    task automatic test_random_traffic();
        int unsigned      useful;
        int unsigned      action;
        int unsigned      n;
        int unsigned      j;
        int unsigned      k;
        int unsigned      tmp;
        int unsigned      seglen;
        int unsigned      offs [24];
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] lim;
        logic [POS_W-1:0] len;
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            lim = window_end();
            if (end_seen && end_pos <= next_pos + 8 && lim != 0 && $urandom_range(0, 2) == 0)
            begin
                // push the end far out so the stream can move on
                send_item(OP_CLOSE, $urandom_range(0, lim - 1), $urandom,
                          POS_MAX - $urandom_range(0, 32'h000F_FFFF), 1'b1);
                useful++;
                continue;
            end
            action = (next_pos - read_pos > 3000) ? 10 : $urandom_range(0, 19);
            if (action < 10)
            begin
                start  = next_pos + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 200) : 0);
                seglen = $urandom_range(1, 24);
                for (j = 0; j < seglen; j++)
                    offs[j] = j;
                if ($urandom_range(0, 2) == 1)
                begin
                    for (j = 0; j < seglen; j++)
                        offs[j] = seglen - 1 - j;
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    for (j = seglen - 1; j > 0; j--)
                    begin
                        k       = $urandom_range(0, j);
                        tmp     = offs[j];
                        offs[j] = offs[k];
                        offs[k] = tmp;
                    end
                end
                for (j = 0; j < seglen; j++)
                    send_item(OP_WRITE, start + offs[j], $urandom, $urandom,
                              $urandom_range(0, 1));
                useful += seglen;
                if ($urandom_range(0, 5) == 0)
                begin
                    send_item(OP_WRITE, start + offs[0], $urandom, $urandom, 1'b0);
                    useful++;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        len = $urandom_range(0, 1) ? $urandom : seglen + $urandom_range(0, 40);
                        send_item(OP_CLOSE, start, $urandom, len, 1'b1);
                    end
                    else
                        send_item(OP_CLOSE, start, $urandom, $urandom, 1'b0);
                    useful++;
                end
            end
            else if (action < 16)
            begin
                n = $urandom_range(1, 16);
                repeat (n) send_item(OP_READ, $urandom, $urandom, $urandom, $urandom_range(0, 1));
                useful += n;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        if (next_pos != 0)
                            send_item(OP_WRITE, $urandom_range(0, next_pos - 1), $urandom,
                                      $urandom, $urandom_range(0, 1));
                        else
                            send_item(OP_WRITE, $urandom, $urandom, $urandom, 1'b0);
                    end
                    1:       send_item(OP_WRITE, lim + $urandom_range(0, 5000), $urandom,
                                       $urandom, $urandom_range(0, 1));
                    2:       send_item(OP_WRITE, $urandom, $urandom, $urandom, 1'b1);
                    3:       send_item(OP_NONE, $urandom, $urandom, $urandom,
                                       $urandom_range(0, 1));
                    default:
                    begin
                        // positions here never reach the upper half of the space
                        if ($urandom_range(0, 1))
                            send_item(OP_CLOSE, $urandom | 32'h8000_0000, $urandom,
                                      $urandom, 1'b1);
                        else
                            send_item(OP_CLOSE, $urandom, $urandom, $urandom, 1'b0);
                    end
                endcase
                noise_sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_NONE;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_unknown();
        test_in_order();
        test_out_of_order();
        test_segment_close();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d items (%0d stale, out-of-window or unknown), checked %0d results",
                 items_sent, noise_sent, results_checked);
        $display("Read back %0d bytes; stream reached position %0d, end flag %0d",
                 bytes_read, next_pos, ended);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
